/* rtl/core/peat_pkg.sv */
package peat_pkg;

	localparam int TableDepth = 1024;
	localparam int AddrBits   = $clog2(TableDepth);
	localparam int CountBits  = AddrBits + 1;

	localparam logic [CountBits-1:0] DEPTH_CNT = CountBits'(TableDepth);

	localparam logic [31:0] RECEIPT_MUL = 32'd2654435761;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_EVICT_THR   = 2'd0;
	localparam logic [1:0] REG_PREDICT_THR = 2'd1;
	localparam logic [1:0] REG_PREDICT_SCL = 2'd2;

	localparam logic [15:0] EVICT_THR_RST   = 16'd62521;
	localparam logic [15:0] PREDICT_THR_RST = 16'd52429;
	localparam logic [15:0] PREDICT_SCL_RST = 16'd58982;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result kinds.
	localparam logic [2:0] KIND_ALLOC   = 3'd0;
	localparam logic [2:0] KIND_REJECT  = 3'd1;
	localparam logic [2:0] KIND_PREDICT = 3'd2;
	localparam logic [2:0] KIND_EVICT   = 3'd3;
	localparam logic [2:0] KIND_FREED   = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN = 3'd5;

	typedef struct packed {
		logic [31:0] handle;
		logic [31:0] size;
		logic [15:0] prio;
	} entry_t;

endpackage

/* rtl/core/peat_ram.sv */
module peat_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/priority_eviction_alloc_table.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: handle, spare_handle, block_size, prio
// m_*       out  m_tvalid/m_tready  tuser: kind; tlast: last;
//                                   tdata: out_handle, out_size, out_prio, receipt
// cfg_*     in   cfg_wen            cfg_idx selects the register, cfg_wdata is the value
//
// One item is worked on at a time. A free scans one entry per cycle up to the match
// and then compacts the entries behind it at one per cycle; an alloc into a full
// table scans all entries for the lowest priority and then, if it evicts, compacts
// the tail. Both the scan and the compaction are bound by the single read and
// write port of the entry memory. The reset clears the entry count and the registers
// only; the memory needs no clearing pass. Results wait in one output register, and
// the sequencer holds while that register is still full.
module priority_eviction_alloc_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: handle[31:0], spare_handle[63:32], block_size[95:64],
	// prio[111:96].
	input  logic [111:0] s_tdata,
	// Fields from bit 0: opcode.
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: out_handle[31:0], out_size[63:32], out_prio[79:64],
	// receipt[143:80].
	output logic [143:0] m_tdata,
	// Fields from bit 0: kind[2:0].
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_idx,
	input  logic [15:0]  cfg_wdata
);

	localparam int AW = peat_pkg::AddrBits;
	localparam int CW = peat_pkg::CountBits;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SCAN     = 4'd1;
	localparam logic [3:0] ST_DECIDE   = 4'd2;
	localparam logic [3:0] ST_EM_EVICT = 4'd3;
	localparam logic [3:0] ST_EM_REJ   = 4'd4;
	localparam logic [3:0] ST_EM_FREE  = 4'd5;
	localparam logic [3:0] ST_EM_UNK   = 4'd6;
	localparam logic [3:0] ST_COMPACT  = 4'd7;
	localparam logic [3:0] ST_APPEND   = 4'd8;
	localparam logic [3:0] ST_EM_ALLOC = 4'd9;
	localparam logic [3:0] ST_EM_PRED  = 4'd10;

	logic [3:0]  state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] idx_q;
	logic        rd_valid_s1;
	logic [CW-1:0] rd_addr_s1;

	logic        op_q;
	logic [31:0] handle_q;
	logic [31:0] spare_q;
	logic [31:0] size_q;
	logic [15:0] prio_q;
	logic [15:0] evict_thr_q;
	logic [15:0] predict_thr_q;
	logic [15:0] predict_scl_q;

	peat_pkg::entry_t best_q;
	logic [63:0] receipt_q;
	logic [15:0] pred_prio_q;

	logic        out_valid_q;
	logic [143:0] out_data_q;
	logic [2:0]  out_kind_q;
	logic        out_last_q;

	// Memory port signals.
	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	peat_pkg::entry_t ram_wdata;
	peat_pkg::entry_t ram_rdata;
	logic        rd_en;

	// Control derived from the state.
	logic        slot_free;
	logic        in_fire;
	logic        scan_last;
	logic        compact_done;
	logic        pred_take;
	logic [31:0] pred_mul;
	logic        out_load;
	logic [2:0]  load_kind;
	logic        load_last;
	peat_pkg::entry_t load_entry;
	logic [63:0] load_receipt;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;

	// Reads run ahead through the table; data comes back in the following cycle tagged
	// with its address.
	assign rd_en = ((state_q == ST_SCAN) || (state_q == ST_COMPACT)) && (rd_q < count_q);
	assign scan_last = rd_valid_s1 && (rd_addr_s1 == count_q - CW'(1));
	assign compact_done = (idx_q == count_q - CW'(1)) || scan_last;
	assign pred_take = (prio_q > predict_thr_q) && (count_q < peat_pkg::DEPTH_CNT);
	assign pred_mul  = {16'd0, prio_q} * {16'd0, predict_scl_q};

	peat_ram #(
		.Width($bits(peat_pkg::entry_t)),
		.Depth(peat_pkg::TableDepth)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Compaction moves each entry one place down; appends go to the tail.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = '{handle: handle_q, size: size_q, prio: prio_q};
		if (state_q == ST_COMPACT) begin
			ram_we    = rd_valid_s1;
			ram_waddr = rd_addr_s1[AW-1:0] - AW'(1);
			ram_wdata = ram_rdata;
		end else if (state_q == ST_APPEND) begin
			ram_we = 1'b1;
		end else if (state_q == ST_EM_PRED) begin
			ram_we    = slot_free;
			ram_wdata = '{handle: spare_q, size: size_q, prio: pred_prio_q};
		end
	end

	// Result selection for the output register.
	always_comb begin
		out_load     = 1'b0;
		load_kind    = peat_pkg::KIND_ALLOC;
		load_last    = 1'b1;
		load_entry   = best_q;
		load_receipt = '0;
		unique case (state_q)
			ST_EM_EVICT: begin
				out_load  = slot_free;
				load_kind = peat_pkg::KIND_EVICT;
				load_last = 1'b0;
			end
			ST_EM_REJ: begin
				out_load   = slot_free;
				load_kind  = peat_pkg::KIND_REJECT;
				load_entry = '{handle: handle_q, size: size_q, prio: prio_q};
			end
			ST_EM_FREE: begin
				out_load  = slot_free;
				load_kind = peat_pkg::KIND_FREED;
			end
			ST_EM_UNK: begin
				out_load   = slot_free;
				load_kind  = peat_pkg::KIND_UNKNOWN;
				load_entry = '{handle: handle_q, size: 32'd0, prio: 16'd0};
			end
			ST_EM_ALLOC: begin
				out_load     = slot_free;
				load_kind    = peat_pkg::KIND_ALLOC;
				load_last    = !pred_take;
				load_entry   = '{handle: handle_q, size: size_q, prio: prio_q};
				load_receipt = receipt_q;
			end
			ST_EM_PRED: begin
				out_load   = slot_free;
				load_kind  = peat_pkg::KIND_PREDICT;
				load_entry = '{handle: spare_q, size: size_q, prio: pred_prio_q};
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				rd_q <= rd_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rd_q <= '0;
						if (s_tuser == peat_pkg::OP_FREE) begin
							state_q <= (count_q == '0) ? ST_EM_UNK : ST_SCAN;
						end else begin
							state_q <= (count_q == peat_pkg::DEPTH_CNT) ? ST_SCAN : ST_APPEND;
						end
					end
				end
				ST_SCAN: begin
					if (op_q == peat_pkg::OP_FREE) begin
						if (rd_valid_s1 && ram_rdata.handle == handle_q) begin
							state_q <= ST_EM_FREE;
						end else if (scan_last) begin
							state_q <= ST_EM_UNK;
						end
					end else if (scan_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= (best_q.prio < evict_thr_q) ? ST_EM_EVICT : ST_EM_REJ;
				end
				ST_EM_EVICT, ST_EM_FREE: begin
					if (slot_free) begin
						rd_q    <= idx_q + CW'(1);
						state_q <= ST_COMPACT;
					end
				end
				ST_EM_REJ, ST_EM_UNK: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COMPACT: begin
					if (compact_done) begin
						count_q <= count_q - CW'(1);
						state_q <= (op_q == peat_pkg::OP_FREE) ? ST_IDLE : ST_APPEND;
					end
				end
				ST_APPEND: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_EM_ALLOC;
				end
				ST_EM_ALLOC: begin
					if (slot_free) begin
						state_q <= pred_take ? ST_EM_PRED : ST_IDLE;
					end
				end
				ST_EM_PRED: begin
					if (slot_free) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request, scan result and arithmetic registers.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_q;
		if (in_fire) begin
			op_q     <= s_tuser;
			handle_q <= s_tdata[31:0];
			spare_q  <= s_tdata[63:32];
			size_q   <= s_tdata[95:64];
			prio_q   <= s_tdata[111:96];
		end
		if (state_q == ST_SCAN && rd_valid_s1) begin
			if (op_q == peat_pkg::OP_FREE) begin
				if (ram_rdata.handle == handle_q) begin
					best_q <= ram_rdata;
					idx_q  <= rd_addr_s1;
				end
			end else if (rd_addr_s1 == '0 || ram_rdata.prio < best_q.prio) begin
				best_q <= ram_rdata;
				idx_q  <= rd_addr_s1;
			end
		end
		if (state_q == ST_APPEND) begin
			receipt_q   <= {32'd0, handle_q ^ size_q} * {32'd0, peat_pkg::RECEIPT_MUL};
			pred_prio_q <= pred_mul[31:16];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evict_thr_q   <= peat_pkg::EVICT_THR_RST;
			predict_thr_q <= peat_pkg::PREDICT_THR_RST;
			predict_scl_q <= peat_pkg::PREDICT_SCL_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				peat_pkg::REG_EVICT_THR:   evict_thr_q   <= cfg_wdata;
				peat_pkg::REG_PREDICT_THR: predict_thr_q <= cfg_wdata;
				peat_pkg::REG_PREDICT_SCL: predict_scl_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {load_receipt, load_entry.prio, load_entry.size, load_entry.handle};
			out_kind_q <= load_kind;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= peat_pkg::DEPTH_CNT)
		else $error("entry count beyond table depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ram_waddr} <= count_q))
		else $error("table write beyond the tail");

	a_evict_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == peat_pkg::KIND_EVICT) |-> !m_tlast)
		else $error("eviction marked as final result");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == peat_pkg::KIND_REJECT || m_tuser == peat_pkg::KIND_FREED
		|| m_tuser == peat_pkg::KIND_UNKNOWN || m_tuser == peat_pkg::KIND_PREDICT)) |-> m_tlast)
		else $error("final result without last");
`endif

endmodule

/* dv/priority_eviction_alloc_table_tb.sv */
`timescale 1ns / 100ps

module priority_eviction_alloc_table_tb;

	// One request as the sender offers it.
	typedef struct {
		logic        op;
		logic [31:0] hnd;
		logic [31:0] spare;
		logic [31:0] sz;
		logic [15:0] pr;
	} req_t;

	// One result as the table is expected to report it.
	typedef struct {
		logic [2:0]  kind;
		logic [31:0] hnd;
		logic [31:0] sz;
		logic [15:0] pr;
		logic [63:0] rcpt;
		logic        last;
	} res_t;

	localparam int IDLE_WAIT = 2300;   // covers a full scan plus compaction
	localparam int DOG_LIMIT = 40000;  // cycles with no item moving on either side
	localparam int HOLD_LEN  = 4000;   // the one long receiver hold-off

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_wen = 1'b0;
	logic [1:0]   cfg_idx = '0;
	logic [15:0]  cfg_wdata = '0;

	priority_eviction_alloc_table uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// The testbench's own copy of the table and the registers.
	logic [31:0] tab_h [peat_pkg::TableDepth];
	logic [31:0] tab_s [peat_pkg::TableDepth];
	logic [15:0] tab_p [peat_pkg::TableDepth];
	int          tab_n = 0;
	logic [15:0] thr_evict   = peat_pkg::EVICT_THR_RST;
	logic [15:0] thr_predict = peat_pkg::PREDICT_THR_RST;
	logic [15:0] scale_pred  = peat_pkg::PREDICT_SCL_RST;

	req_t        pend_q[$];
	res_t        want_q[$];
	logic [31:0] known_q[$];   // handles that were offered for alloc, used to pick frees

	int errs = 0;
	int n_in = 0;
	int n_out = 0;
	int kind_seen [6];

	// Removal shifts the tail down so the table order is kept.
	task automatic tab_remove(input int idx);
		for (int j = idx; j < tab_n - 1; j++) begin
			tab_h[j] = tab_h[j+1];
			tab_s[j] = tab_s[j+1];
			tab_p[j] = tab_p[j+1];
		end
		tab_n--;
	endtask

	task automatic tab_append(input logic [31:0] h, input logic [31:0] s, input logic [15:0] p);
		tab_h[tab_n] = h;
		tab_s[tab_n] = s;
		tab_p[tab_n] = p;
		tab_n++;
	endtask

	task automatic push_res(input logic [2:0] k, input logic [31:0] h, input logic [31:0] s,
			input logic [15:0] p, input logic [63:0] rc, input logic lst);
		res_t r;
		r.kind = k; r.hnd = h; r.sz = s; r.pr = p; r.rcpt = rc; r.last = lst;
		want_q.push_back(r);
	endtask

	// Works out the results of one accepted request and updates the table copy.
	task automatic table_step(input req_t q);
		int mi;
		int hit;
		logic [15:0] pp;
		logic [31:0] prod;
		logic        do_pred;
		if (q.op == peat_pkg::OP_FREE) begin
			hit = -1;
			for (int i = 0; i < tab_n; i++)
				if (hit < 0 && tab_h[i] == q.hnd) hit = i;
			if (hit >= 0) begin
				push_res(peat_pkg::KIND_FREED, q.hnd, tab_s[hit], tab_p[hit], 64'd0, 1'b1);
				tab_remove(hit);
			end else begin
				push_res(peat_pkg::KIND_UNKNOWN, q.hnd, 32'd0, 16'd0, 64'd0, 1'b1);
			end
		end else begin
			if (tab_n >= peat_pkg::TableDepth) begin
				// The first entry holding the lowest priority is the candidate.
				mi = 0;
				for (int i = 1; i < tab_n; i++)
					if (tab_p[i] < tab_p[mi]) mi = i;
				if (tab_p[mi] < thr_evict) begin
					push_res(peat_pkg::KIND_EVICT, tab_h[mi], tab_s[mi], tab_p[mi], 64'd0, 1'b0);
					tab_remove(mi);
				end else begin
					push_res(peat_pkg::KIND_REJECT, q.hnd, q.sz, q.pr, 64'd0, 1'b1);
					return;
				end
			end
			tab_append(q.hnd, q.sz, q.pr);
			do_pred = (q.pr > thr_predict) && (tab_n < peat_pkg::TableDepth);
			push_res(peat_pkg::KIND_ALLOC, q.hnd, q.sz, q.pr,
				({32'd0, q.hnd} ^ {32'd0, q.sz}) * {32'd0, peat_pkg::RECEIPT_MUL}, !do_pred);
			if (do_pred) begin
				prod = {16'd0, q.pr} * {16'd0, scale_pred};
				pp = prod[31:16];
				tab_append(q.spare, q.sz, pp);
				push_res(peat_pkg::KIND_PREDICT, q.spare, q.sz, pp, 64'd0, 1'b1);
			end
		end
	endtask

	// Driver: bursts of random length, with random gaps between them.
	req_t cur;
	int   burst_left = 0;
	int   gap_left = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			table_step(cur);
			n_in++;
		end
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				cur = pend_q.pop_front();
				s_tdata <= {cur.pr, cur.sz, cur.spare, cur.hnd};
				s_tuser <= cur.op;
				s_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off so the block backs up.
	int  rx_cyc = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	res_t exp_r;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			n_out++;
			if (m_tuser < 6) kind_seen[m_tuser]++;
			if (want_q.size() == 0) begin
				$error("result with nothing expected: kind %0d handle %h", m_tuser, m_tdata[31:0]);
				errs++;
			end else begin
				exp_r = want_q.pop_front();
				if (m_tuser !== exp_r.kind) begin
					$error("kind: expected %0d, got %0d", exp_r.kind, m_tuser); errs++;
				end
				if (m_tdata[31:0] !== exp_r.hnd) begin
					$error("out_handle: expected %h, got %h", exp_r.hnd, m_tdata[31:0]); errs++;
				end
				if (m_tdata[63:32] !== exp_r.sz) begin
					$error("out_size: expected %h, got %h", exp_r.sz, m_tdata[63:32]); errs++;
				end
				if (m_tdata[79:64] !== exp_r.pr) begin
					$error("out_prio: expected %h, got %h", exp_r.pr, m_tdata[79:64]); errs++;
				end
				if (m_tdata[143:80] !== exp_r.rcpt) begin
					$error("receipt: expected %h, got %h", exp_r.rcpt, m_tdata[143:80]); errs++;
				end
				if (m_tlast !== exp_r.last) begin
					$error("last: expected %b, got %b", exp_r.last, m_tlast); errs++;
				end
			end
		end
		rx_cyc++;
		if (!hold_done && n_out >= 400) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if ((rx_cyc % 700) < 150) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Watchdog: too long with no item moving on either side ends the run.
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
		else quiet++;
		if (quiet > DOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic add_req(input logic op, input logic [31:0] h, input logic [31:0] sp,
			input logic [31:0] s, input logic [15:0] p);
		req_t q;
		q.op = op; q.hnd = h; q.spare = sp; q.sz = s; q.pr = p;
		pend_q.push_back(q);
		if (op == peat_pkg::OP_ALLOC) known_q.push_back(h);
	endtask

	// Waits until the block has nothing left to do, then lets the tail work finish.
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pend_q.size() > 0 || s_tvalid || want_q.size() > 0);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			peat_pkg::REG_EVICT_THR:   thr_evict = val;
			peat_pkg::REG_PREDICT_THR: thr_predict = val;
			default:                   scale_pred = val;
		endcase
	endtask

	task automatic cfg_done();
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [31:0] pick_free_handle();
		if (known_q.size() == 0 || $urandom_range(0, 5) == 0) return $urandom();
		return known_q[$urandom_range(0, known_q.size() - 1)];
	endfunction

	// Random traffic around a full table: allocs and frees of mostly known handles.
	task automatic random_batch(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1) == 0)
				add_req(peat_pkg::OP_ALLOC, $urandom(), $urandom(), $urandom(),
					16'($urandom_range(0, 65535)));
			else
				add_req(peat_pkg::OP_FREE, pick_free_handle(), $urandom(), $urandom(),
					16'($urandom()));
		end
	endtask

	initial begin
		logic [15:0] p;
		int          fill;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings: empty-table free, field extremes,
		// prediction just at and just above its threshold, and duplicate handles.
		add_req(peat_pkg::OP_FREE, 32'h0000_0000, 32'h0, 32'h0, 16'h0);
		add_req(peat_pkg::OP_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
		add_req(peat_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
		add_req(peat_pkg::OP_ALLOC, 32'h1234_5678, 32'h8765_4321, 32'h0000_1000,
			peat_pkg::PREDICT_THR_RST);
		add_req(peat_pkg::OP_ALLOC, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0040,
			peat_pkg::PREDICT_THR_RST + 16'd1);
		add_req(peat_pkg::OP_ALLOC, 32'hDEAD_0001, 32'h0, 32'h11, 16'd100);
		add_req(peat_pkg::OP_ALLOC, 32'hDEAD_0001, 32'h0, 32'h22, 16'd200);
		add_req(peat_pkg::OP_FREE, 32'hDEAD_0001, 32'h0, 32'h0, 16'h0);
		add_req(peat_pkg::OP_FREE, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0);
		add_req(peat_pkg::OP_FREE, 32'hCAFE_F00D, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		wait_idle();

		// Every alloc brings a predicted entry while the table is filled, so it fills
		// in half as many items; predicted priorities are one below the alloc's.
		cfg_write(peat_pkg::REG_EVICT_THR, 16'hFFFF);
		cfg_write(peat_pkg::REG_PREDICT_THR, 16'h0000);
		cfg_write(peat_pkg::REG_PREDICT_SCL, 16'hFFFF);
		cfg_done();
		fill = (peat_pkg::TableDepth - tab_n + 1) / 2;
		for (int i = 0; i < fill; i++) begin
			// Two predicted entries get priority zero so the first one must go first.
			p = (i == 150 || i == 350) ? 16'd1 : 16'($urandom_range(2, 65535));
			add_req(peat_pkg::OP_ALLOC, $urandom(), $urandom(), $urandom(), p);
		end
		// A full table: the first two entries of priority zero are evicted in order.
		add_req(peat_pkg::OP_ALLOC, 32'h0BAD_0001, 32'h1, 32'h10, 16'hFFFF);
		add_req(peat_pkg::OP_ALLOC, 32'h0BAD_0002, 32'h2, 32'h20, 16'h8000);
		wait_idle();

		// Nothing is below a zero threshold, so every alloc is rejected.
		cfg_write(peat_pkg::REG_EVICT_THR, 16'h0000);
		cfg_done();
		add_req(peat_pkg::OP_ALLOC, 32'h0BAD_0003, 32'h3, 32'hFFFF_FFFF, 16'h0000);
		add_req(peat_pkg::OP_ALLOC, 32'h0BAD_0004, 32'h4, 32'h0, 16'hFFFF);
		add_req(peat_pkg::OP_FREE, 32'h0BAD_0001, 32'h0, 32'h0, 16'h0);
		add_req(peat_pkg::OP_FREE, 32'h0BAD_0002, 32'h0, 32'h0, 16'h0);
		wait_idle();

		// Prediction with full scale once room is free, then no room left for it.
		cfg_write(peat_pkg::REG_EVICT_THR, peat_pkg::EVICT_THR_RST);
		cfg_write(peat_pkg::REG_PREDICT_THR, 16'h0000);
		cfg_write(peat_pkg::REG_PREDICT_SCL, 16'hFFFF);
		cfg_done();
		add_req(peat_pkg::OP_ALLOC, 32'h0BAD_0005, 32'h0BAD_0006, 32'h55, 16'hFFFF);
		add_req(peat_pkg::OP_ALLOC, 32'h0BAD_0007, 32'h0BAD_0008, 32'h77, 16'h0001);
		random_batch(20);
		wait_idle();

		for (int ph = 0; ph < 3; ph++) begin
			cfg_write(peat_pkg::REG_EVICT_THR, (ph == 1) ? 16'hFFFF : 16'($urandom()));
			cfg_write(peat_pkg::REG_PREDICT_THR, (ph == 2) ? 16'hFFFF : 16'($urandom()));
			cfg_write(peat_pkg::REG_PREDICT_SCL, (ph == 0) ? 16'h8000 : 16'($urandom()));
			cfg_done();
			random_batch(15);
			wait_idle();
		end

		$display("Covered %0d items and %0d results over seven register settings.", n_in, n_out);
		$display("Kinds seen: alloc %0d reject %0d predict %0d evict %0d freed %0d unknown %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5]);
		if (errs == 0 && want_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
